// ----- sv/deq_pkg.sv -----
// Shared types, constants and helper functions for the double-ended queue.
// Used by the interfaces, the controller, the memory and the response stage.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   // Storage geometry.
   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Operation codes carried by a request.
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4
   } opcode_type;

   // Outcome codes carried by a response.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One access to the element memory.
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      ptr_type            addr;
      logic [DATA_W-1:0]  wr_data;
   } mem_cmd_type;

   // Response fields known at acceptance time.
   typedef struct packed {
      logic       pop_ok;
      status_type status;
      cnt_type    count;
   } rsp_meta_type;

   // Pointer step forward with wrap at the end of the store.
   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   // Pointer step backward with wrap at the start of the store.
   function automatic ptr_type ptr_dec(input ptr_type p);
      ptr_type r;
      if (p == '0) begin
         r = ptr_type'(DEPTH - 1);
      end else begin
         r = p - ptr_type'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/deq_req_if.sv -----
// Request channel interface: valid/ready handshake with opcode and data.
// Depends on deq_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       opcode;
   logic signed [deq_pkg::DATA_W-1:0] data_in;

   modport source (output valid, output opcode, output data_in, input ready);
   modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

`default_nettype wire

// ----- sv/deq_rsp_if.sv -----
// Response channel interface: valid/ready handshake with the result fields.
// Depends on deq_pkg for the data and count widths.
`timescale 1ns / 1ps
`default_nettype none

interface deq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [deq_pkg::DATA_W-1:0] data_out;
   logic [1:0]                        status;
   logic [deq_pkg::CNT_W-1:0]         count;
   logic                              is_empty;

   modport source (output valid, output data_out, output status, output count,
                   output is_empty, input ready);
   modport sink   (input valid, input data_out, input status, input count,
                   input is_empty, output ready);
endinterface

`default_nettype wire

// ----- sv/deq_ctrl.sv -----
// Pointer and count controller: decodes a request, updates front, back and
// count, and issues at most one memory access. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [2:0]                  opcode,
   input  wire logic [deq_pkg::DATA_W-1:0]  data_in,
   output deq_pkg::mem_cmd_type             mem_cmd,
   output deq_pkg::rsp_meta_type            meta
);

   deq_pkg::ptr_type front_ff, front_in;
   deq_pkg::ptr_type back_ff, back_in;
   deq_pkg::cnt_type count_ff, count_in;
   deq_pkg::opcode_type op;
   logic full;
   logic empty;

   assign op    = deq_pkg::opcode_type'(opcode);
   assign full  = (count_ff == deq_pkg::cnt_type'(deq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   // Decode the operation into the next pointer state and a memory access.
   always_comb begin
      front_in        = front_ff;
      back_in         = back_ff;
      count_in        = count_ff;
      mem_cmd.wr_en   = 1'b0;
      mem_cmd.rd_en   = 1'b0;
      mem_cmd.addr    = front_ff;
      mem_cmd.wr_data = data_in;
      meta.pop_ok     = 1'b0;
      meta.status     = deq_pkg::ST_OK;
      unique case (op)
         deq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               meta.status = deq_pkg::ST_FULL;
            end else begin
               front_in      = deq_pkg::ptr_dec(front_ff);
               mem_cmd.addr  = front_in;
               mem_cmd.wr_en = accept;
               count_in      = count_ff + deq_pkg::cnt_type'(1);
            end
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               meta.status = deq_pkg::ST_FULL;
            end else begin
               mem_cmd.addr  = back_ff;
               mem_cmd.wr_en = accept;
               back_in       = deq_pkg::ptr_inc(back_ff);
               count_in      = count_ff + deq_pkg::cnt_type'(1);
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               meta.status = deq_pkg::ST_EMPTY;
            end else begin
               mem_cmd.addr  = front_ff;
               mem_cmd.rd_en = accept;
               meta.pop_ok   = 1'b1;
               front_in      = deq_pkg::ptr_inc(front_ff);
               count_in      = count_ff - deq_pkg::cnt_type'(1);
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (empty) begin
               meta.status = deq_pkg::ST_EMPTY;
            end else begin
               back_in       = deq_pkg::ptr_dec(back_ff);
               mem_cmd.addr  = back_in;
               mem_cmd.rd_en = accept;
               meta.pop_ok   = 1'b1;
               count_in      = count_ff - deq_pkg::cnt_type'(1);
            end
         end
         deq_pkg::OP_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
            // Unused codes leave everything as it is.
         end
      endcase
      meta.count = count_in;
   end

   // Pointer and count registers advance only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/deq_mem.sv -----
// Element store: single-port synchronous memory with a registered read.
// Depends on deq_pkg for geometry and the access struct.
`timescale 1ns / 1ps
`default_nettype none

module deq_mem (
   input  wire logic                        clock,
   input  wire deq_pkg::mem_cmd_type        mem_cmd,
   output logic [deq_pkg::DATA_W-1:0]       rd_data
);

   logic [deq_pkg::DATA_W-1:0] store_mem [deq_pkg::DEPTH];
   logic [deq_pkg::DATA_W-1:0] rd_data_ff;

   // One write or one read per cycle; read data appears after the edge.
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store_mem[mem_cmd.addr] <= mem_cmd.wr_data;
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff <= store_mem[mem_cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/deq_rsp.sv -----
// Response register stage: holds one result until the receiver takes it and
// merges the memory read data. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_rsp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire deq_pkg::rsp_meta_type       meta,
   input  wire logic [deq_pkg::DATA_W-1:0]  rd_data,
   input  wire logic                        rsp_ready,
   output logic                             free,
   output logic                             rsp_valid,
   output logic [deq_pkg::DATA_W-1:0]       rsp_data,
   output logic [1:0]                       rsp_status,
   output deq_pkg::cnt_type                 rsp_count,
   output logic                             rsp_is_empty
);

   logic                  valid_ff, valid_in;
   deq_pkg::rsp_meta_type meta_ff;

   // The slot is free when empty or when its result leaves this cycle.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result fields are captured with the request.
   always_ff @(posedge clock) begin
      if (load) begin
         meta_ff <= meta;
      end
   end

   // The read data register only changes on a new request, so it holds too.
   assign rsp_valid    = valid_ff;
   assign rsp_data     = meta_ff.pop_ok ? rd_data : '0;
   assign rsp_status   = meta_ff.status;
   assign rsp_count    = meta_ff.count;
   assign rsp_is_empty = (meta_ff.count == '0);

endmodule

`default_nettype wire

// ----- sv/double_ended_queue.sv -----
// Double-ended queue top level: controller, element memory, response stage.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_ctrl, deq_mem, deq_rsp.
//
// Usage:
//   req_ch carries one operation per request: push front, push back,
//   pop front, pop back or clear, with a data word used by pushes.
//   rsp_ch returns exactly one response per request, in order: the popped
//   word (zero unless a pop succeeded), a status (ok, empty, full), the
//   element count after the operation and an empty flag.
//   Response: valid in the cycle after the request is accepted, when the
//   element memory's registered read data is available.
//   Throughput: one request per cycle while not stalled; pointers and
//   count update at the accepting edge; one memory read or write per cycle.
//   Stall: a single response register holds the result; req_ch.ready is
//   low while that register is full and rsp_ch.ready is low.
//   Reset: synchronous; pointers and count go to zero, no response pending.
//   The element memory is not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
   input  wire logic clock,
   input  wire logic reset,
   deq_req_if.sink   req_ch,
   deq_rsp_if.source rsp_ch
);

   logic                       accept;
   logic                       rsp_free;
   deq_pkg::mem_cmd_type       mem_cmd;
   deq_pkg::rsp_meta_type      meta;
   logic [deq_pkg::DATA_W-1:0] rd_data;
   logic [deq_pkg::DATA_W-1:0] rsp_data;

   // A request is taken whenever the response slot can receive its result.
   assign req_ch.ready = rsp_free;
   assign accept       = req_ch.valid && rsp_free;

   deq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .opcode  (req_ch.opcode),
      .data_in (req_ch.data_in),
      .mem_cmd (mem_cmd),
      .meta    (meta)
   );

   deq_mem u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   deq_rsp u_rsp (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .meta         (meta),
      .rd_data      (rd_data),
      .rsp_ready    (rsp_ch.ready),
      .free         (rsp_free),
      .rsp_valid    (rsp_ch.valid),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_ch.status),
      .rsp_count    (rsp_ch.count),
      .rsp_is_empty (rsp_ch.is_empty)
   );

   assign rsp_ch.data_out = rsp_data;

   // A successful push raises the reported count by exactly one.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && (meta.status == deq_pkg::ST_OK) &&
      (req_ch.opcode == deq_pkg::OP_PUSH_FRONT || req_ch.opcode == deq_pkg::OP_PUSH_BACK)
      |=> (rsp_ch.count == $past(u_ctrl.count_ff) + deq_pkg::cnt_type'(1)))
      else $error("push did not increment the count");

   // A pop refused as empty always reports an empty deque.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == deq_pkg::ST_EMPTY)
      |-> (rsp_ch.count == '0) && rsp_ch.is_empty)
      else $error("empty status with nonzero count");

   // No response is pending right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid after reset");

   // Every accepted request produces a pending response on the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ch.valid)
      else $error("accepted request without a response");

endmodule

`default_nettype wire
